@@ rtl/core/mbic_pkg.sv @@
package mbic_pkg;

    // Sizes
    localparam int MAX_OBJECTS = 64;
    localparam int OBJ_AW      = $clog2(MAX_OBJECTS);
    localparam int MAX_ROWS    = 65536;
    localparam int CNT_W       = 17;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;
    localparam int ENTRY_CAP   = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;
    localparam int ROW_W       = 64;
    localparam int NUM_W       = 7;
    localparam int CHUNK_W     = 8;
    localparam int NCHUNK      = ROW_W / CHUNK_W;
    localparam int CHUNK_AW    = $clog2(NCHUNK);

    // Opcodes
    localparam logic OP_ROW  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_POS   = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef struct packed {
        logic                opcode;
        logic [ROW_W-1:0]    row_bits;
        logic [OBJ_AW-1:0]   object_index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]          kind;
        logic [CNT_W-1:0]    entry_number;
        logic [OBJ_AW-1:0]   position;
        logic [NUM_W-1:0]    list_length;
        logic                compacted;
        logic                last;
        logic [CNT_W-1:0]    counter_value;
        logic [CNT_W-1:0]    total_compacted;
        logic [CNT_W-1:0]    skipped_rows;
    } t_out_beat;

    // Saturating increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        r = (v < cap) ? v + 1'b1 : cap;
        return r;
    endfunction

    // Mask of the low n bits of a row
    function automatic logic [ROW_W-1:0] row_mask(input logic [NUM_W-1:0] n);
        logic [ROW_W-1:0] m;
        for (int i = 0; i < ROW_W; i++) begin
            m[i] = NUM_W'(i) < n;
        end
        return m;
    endfunction

endpackage

@@ rtl/core/minority_bit_index_compactor.sv @@
// Minority-bit index compactor.
// Input channel (i_in_valid / o_in_ready, i_in_beat): one beat is either a
// bit row to list (opcode row) or a counter readout request (opcode read).
// Output channel (o_out_valid / i_out_ready, o_out_beat): a row gives one
// beat per listed position, or one empty-row beat; a readout gives one beat.
// The last beat of each item has last set.
// Config: i_cfg_we / i_cfg_wdata write num_objects; write only while idle.
// Sequence: a readout reads its counter from the registered store, then loads
// its beat, and the block takes the next item. A row passes through the
// byte-wide bit counter and a decision state, then the scan walks the row one
// bit per cycle unless the receiver stalls and stops after the last listed
// bit; each listed position gets its beat as the scan reaches it. An empty row
// gets one beat after the decision. A compacted row also keeps the block busy
// until the final counter write-back. The block holds one item at a time;
// o_in_ready is low meanwhile.
// When the receiver stalls, the scan waits at the next listed position; the
// loaded output beat holds. Reset clears all counters, totals and the entry
// number and sets num_objects to 64; no clearing pass is needed.
module minority_bit_index_compactor (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [6:0]              i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  mbic_pkg::t_in_beat      i_in_beat,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output mbic_pkg::t_out_beat     o_out_beat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_EMPTY  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;

    localparam int NW = mbic_pkg::NUM_W;
    localparam int CW = mbic_pkg::CNT_W;
    localparam int AW = mbic_pkg::OBJ_AW;
    localparam int RW = mbic_pkg::ROW_W;

    localparam logic [CW-1:0] CAP_CNT   = CW'(mbic_pkg::CNT_MAX);
    localparam logic [CW-1:0] CAP_ENTRY = CW'(mbic_pkg::ENTRY_CAP);
    localparam logic [NW-1:0] N_MAX     = NW'(mbic_pkg::MAX_OBJECTS);

    logic [2:0]                     r_state, n_state;
    logic [NW-1:0]                  r_num_obj;
    logic [NW-1:0]                  r_n, n_n;
    logic [RW-1:0]                  r_row, n_row;
    logic [mbic_pkg::CHUNK_AW-1:0]  r_chunk, n_chunk;
    logic [AW-1:0]                  r_idx, n_idx;
    logic                           r_comp, n_comp;
    logic [NW-1:0]                  r_len, n_len;
    logic [CW-1:0]                  r_next_entry, n_next_entry;
    logic [CW-1:0]                  r_skipped, n_skipped;
    logic [CW-1:0]                  r_total, n_total;
    logic                           r_wr_pend, n_wr_pend;
    logic [AW-1:0]                  r_wr_addr, n_wr_addr;
    logic                           r_out_valid, n_out_valid;
    mbic_pkg::t_out_beat            r_out, n_out;

    logic                           w_in_fire;
    logic                           w_out_free;
    logic [NW-1:0]                  w_n_in;
    logic                           w_pc_clr;
    logic                           w_pc_en;
    logic [mbic_pkg::CHUNK_W-1:0]   w_chunk;
    logic [NW-1:0]                  w_ones;
    logic                           w_comp;
    logic                           w_rd_en;
    logic [AW-1:0]                  w_rd_addr;
    logic [CW-1:0]                  w_rd_data;

    assign o_in_ready = (r_state == S_IDLE) && !r_wr_pend;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // row length clipped to the object limit
    assign w_n_in  = (r_num_obj > N_MAX) ? N_MAX : r_num_obj;
    assign w_chunk = r_row[{r_chunk, 3'b000} +: mbic_pkg::CHUNK_W];
    assign w_comp  = w_ones > (r_n >> 1);

    mbic_popc u_popc (
        .i_clk   (i_clk),
        .i_clr   (w_pc_clr),
        .i_en    (w_pc_en),
        .i_chunk (w_chunk),
        .o_ones  (w_ones)
    );

    mbic_cnt_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_wr_pend),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (mbic_pkg::sat_inc(w_rd_data, CAP_CNT))
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_row        = r_row;
        n_chunk      = r_chunk;
        n_idx        = r_idx;
        n_comp       = r_comp;
        n_len        = r_len;
        n_next_entry = r_next_entry;
        n_skipped    = r_skipped;
        n_total      = r_total;
        n_wr_pend    = 1'b0;
        n_wr_addr    = r_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        w_pc_clr     = 1'b0;
        w_pc_en      = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in_beat.opcode == mbic_pkg::OP_READ) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = i_in_beat.object_index;
                        n_state   = S_READ;
                    end else begin
                        n_n      = w_n_in;
                        n_row    = i_in_beat.row_bits & mbic_pkg::row_mask(w_n_in);
                        n_chunk  = '0;
                        w_pc_clr = 1'b1;
                        n_state  = S_COUNT;
                    end
                end
            end
            S_COUNT: begin
                w_pc_en = 1'b1;
                n_chunk = r_chunk + 1'b1;
                if (&r_chunk) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_comp = w_comp;
                n_idx  = '0;
                if (w_comp) begin
                    n_row   = ~r_row & mbic_pkg::row_mask(r_n);
                    n_len   = r_n - w_ones;
                    n_total = mbic_pkg::sat_inc(r_total, CAP_CNT);
                end else begin
                    n_len = w_ones;
                end
                if (n_len == '0) begin
                    n_skipped = mbic_pkg::sat_inc(r_skipped, CAP_CNT);
                    n_state   = S_EMPTY;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // one bit per cycle; a listed bit waits for a free output slot
                if (!r_row[0] || w_out_free) begin
                    n_row = r_row >> 1;
                    n_idx = r_idx + 1'b1;
                end
                if (r_row[0] && w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out                = '0;
                    n_out.kind           = mbic_pkg::KIND_POS;
                    n_out.entry_number   = r_next_entry;
                    n_out.position       = r_idx;
                    n_out.list_length    = r_len;
                    n_out.compacted      = r_comp;
                    n_out.last           = ~|r_row[RW-1:1];
                    // counter update: read now, write back next cycle
                    w_rd_en              = r_comp;
                    n_wr_pend            = r_comp;
                    if (!(|r_row[RW-1:1])) begin
                        n_next_entry = mbic_pkg::sat_inc(r_next_entry, CAP_ENTRY);
                        n_state      = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.kind         = mbic_pkg::KIND_EMPTY;
                    n_out.entry_number = r_next_entry;
                    n_out.compacted    = r_comp;
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out                 = '0;
                    n_out.kind            = mbic_pkg::KIND_READ;
                    n_out.entry_number    = r_next_entry;
                    n_out.last            = 1'b1;
                    n_out.counter_value   = w_rd_data;
                    n_out.total_compacted = r_total;
                    n_out.skipped_rows    = r_skipped;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_num_obj    <= N_MAX;
            r_next_entry <= '0;
            r_skipped    <= '0;
            r_total      <= '0;
            r_wr_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_entry <= n_next_entry;
            r_skipped    <= n_skipped;
            r_total      <= n_total;
            r_wr_pend    <= n_wr_pend;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_num_obj <= i_cfg_wdata;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_row     <= n_row;
        r_chunk   <= n_chunk;
        r_idx     <= n_idx;
        r_comp    <= n_comp;
        r_len     <= n_len;
        r_wr_addr <= n_wr_addr;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

@@ rtl/core/mbic_popc.sv @@
// Accumulating bit counter: adds the ones of one byte per cycle while enabled
module mbic_popc (
    input  logic                            i_clk,
    input  logic                            i_clr,
    input  logic                            i_en,
    input  logic [mbic_pkg::CHUNK_W-1:0]    i_chunk,
    output logic [mbic_pkg::NUM_W-1:0]      o_ones
);

    logic [mbic_pkg::NUM_W-1:0] r_acc;
    logic [mbic_pkg::NUM_W-1:0] n_acc;
    logic [mbic_pkg::NUM_W-1:0] w_sum;

    // ones in this byte
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < mbic_pkg::CHUNK_W; i++) begin
            w_sum = w_sum + mbic_pkg::NUM_W'(i_chunk[i]);
        end
        n_acc = r_acc + w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_ones = r_acc;

endmodule

@@ rtl/core/mbic_cnt_mem.sv @@
// Per-object counter store: one read and one write port, registered read,
// per-entry valid bits so that an unwritten entry reads as zero after reset
module mbic_cnt_mem (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [mbic_pkg::OBJ_AW-1:0]     i_rd_addr,
    output logic [mbic_pkg::CNT_W-1:0]      o_rd_data,
    input  logic                            i_wr_en,
    input  logic [mbic_pkg::OBJ_AW-1:0]     i_wr_addr,
    input  logic [mbic_pkg::CNT_W-1:0]      i_wr_data
);

    logic [mbic_pkg::CNT_W-1:0]         r_mem [mbic_pkg::MAX_OBJECTS];
    logic [mbic_pkg::MAX_OBJECTS-1:0]   r_vld;
    logic [mbic_pkg::CNT_W-1:0]         r_rd_data;
    logic                               r_rd_vld;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/core/mbic_chk.sv @@
// Port-level checks for the compactor
module mbic_chk (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [6:0]              i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    o_in_ready,
    input  mbic_pkg::t_in_beat      i_in_beat,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  mbic_pkg::t_out_beat     o_out_beat
);

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat dropped or changed under stall");

    // an accepted item leaves the block busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

    // a list still in progress blocks new items
    a_list_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_beat.last |-> !o_in_ready)
        else $error("ready while a list is still being emitted");

    // single-beat kinds are always last and carry no list length
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.kind == mbic_pkg::KIND_EMPTY ||
                        o_out_beat.kind == mbic_pkg::KIND_READ)
        |-> o_out_beat.last && (o_out_beat.list_length == '0))
        else $error("empty or readout beat malformed");

endmodule

bind minority_bit_index_compactor mbic_chk u_mbic_chk (.*);

@@ tb/minority_list_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the compactor, predicts every output beat from the
// accepted input beats and the num_objects writes, and compares in order.
module minority_list_checker
    import mbic_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_beat         i_in_beat,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_beat        i_out_beat,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beat_count,
    output int               o_compacted_rows
);

    // Shadow state of the block
    logic [CNT_W-1:0] obj_hits [MAX_OBJECTS];
    logic [CNT_W-1:0] entry_no;
    logic [CNT_W-1:0] skip_cnt;
    logic [CNT_W-1:0] comp_tot;
    logic [NUM_W-1:0] width_reg;

    // Beats still owed by the block, oldest first
    t_out_beat list_beats_due [$];

    // Saturating count step
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v, input int cap);
        return (int'(v) < cap) ? v + 1'b1 : CNT_W'(cap);
    endfunction

    // Work out the beats one accepted item causes and update the shadow state
    task automatic forecast(input t_in_beat b);
        t_out_beat        e;
        int               n;
        int               len;
        int               k;
        bit               comp;
        logic [ROW_W-1:0] mask;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] picks;
        e = '0;
        if (b.opcode == OP_READ) begin
            e.kind            = KIND_READ;
            e.entry_number    = entry_no;
            e.last            = 1'b1;
            e.counter_value   = obj_hits[b.object_index];
            e.total_compacted = comp_tot;
            e.skipped_rows    = skip_cnt;
            list_beats_due.push_back(e);
            return;
        end
        // widths above the row size behave as a full row
        n     = (int'(width_reg) > MAX_OBJECTS) ? MAX_OBJECTS : int'(width_reg);
        mask  = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - 1'b1);
        row   = b.row_bits & mask;
        comp  = $countones(row) > (n / 2);
        picks = comp ? (~row & mask) : row;
        len   = $countones(picks);
        if (comp) begin
            comp_tot = bump(comp_tot, CNT_MAX);
            o_compacted_rows++;
        end
        // empty list: a single beat, no entry number consumed
        if (len == 0) begin
            skip_cnt       = bump(skip_cnt, CNT_MAX);
            e.kind         = KIND_EMPTY;
            e.entry_number = entry_no;
            e.compacted    = comp;
            e.last         = 1'b1;
            list_beats_due.push_back(e);
            return;
        end
        k = 0;
        for (int i = 0; i < n; i++) begin
            if (picks[i]) begin
                if (comp) obj_hits[i] = bump(obj_hits[i], CNT_MAX);
                e              = '0;
                e.kind         = KIND_POS;
                e.entry_number = entry_no;
                e.position     = OBJ_AW'(i);
                e.list_length  = NUM_W'(len);
                e.compacted    = comp;
                e.last         = (k + 1 == len);
                list_beats_due.push_back(e);
                k++;
            end
        end
        entry_no = bump(entry_no, ENTRY_CAP);
    endtask

    task automatic show(input string tag, input t_out_beat b);
        $display("  %s kind=%0d entry=%0d pos=%0d len=%0d comp=%0b last=%0b",
                 tag, b.kind, b.entry_number, b.position, b.list_length, b.compacted, b.last);
        $display("  %s   counter=%0d total=%0d skipped=%0d",
                 tag, b.counter_value, b.total_compacted, b.skipped_rows);
    endtask

    // Compare one output beat with the oldest prediction
    task automatic check_beat(input t_out_beat got);
        t_out_beat e;
        string     bad;
        o_beat_count++;
        if (list_beats_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: output beat with nothing expected", $time);
                show("got", got);
            end
            return;
        end
        e   = list_beats_due.pop_front();
        bad = "";
        if (got.kind !== e.kind)                       bad = {bad, " kind"};
        if (got.entry_number !== e.entry_number)       bad = {bad, " entry_number"};
        if (got.position !== e.position)               bad = {bad, " position"};
        if (got.list_length !== e.list_length)         bad = {bad, " list_length"};
        if (got.compacted !== e.compacted)             bad = {bad, " compacted"};
        if (got.last !== e.last)                       bad = {bad, " last"};
        if (got.counter_value !== e.counter_value)     bad = {bad, " counter_value"};
        if (got.total_compacted !== e.total_compacted) bad = {bad, " total_compacted"};
        if (got.skipped_rows !== e.skipped_rows)       bad = {bad, " skipped_rows"};
        if (bad != "") begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("%0t: mismatch on beat %0d in:%s", $time, o_beat_count, bad);
                show("exp", e);
                show("got", got);
            end
        end
    endtask

    // Sample both channels and the config port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (obj_hits[i]) obj_hits[i] = '0;
            entry_no  = '0;
            skip_cnt  = '0;
            comp_tot  = '0;
            width_reg = NUM_W'(64);
            list_beats_due.delete();
        end else begin
            if (i_cfg_we) width_reg = i_cfg_wdata;
            if (i_out_valid && i_out_ready) check_beat(i_out_beat);
            if (i_in_valid && i_in_ready) forecast(i_in_beat);
        end
        o_pending <= list_beats_due.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mbic_pkg::*;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [NUM_W-1:0] cfg_wdata = NUM_W'(64);
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in_beat         in_beat   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_beat        out_beat;

    int fail_count;
    int pending;
    int beat_count;
    int compacted_rows;

    // stimulus bookkeeping
    bit               quiet      = 1'b0;
    logic [NUM_W-1:0] cur_width  = NUM_W'(64);
    int               row_items  = 0;
    int               read_items = 0;
    int               settings   = 0;

    always #2 clk = ~clk;

    minority_bit_index_compactor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    minority_list_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_beat        (in_beat),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_beat       (out_beat),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_beat_count     (beat_count),
        .o_compacted_rows (compacted_rows)
    );

    // Receiver: stalls at random unless in a quiet stretch
    always @(posedge clk) begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 36);
    end

    function automatic bit take_gap();
        return !quiet && ($urandom_range(0, 99) < 36);
    endfunction

    // Present one beat, with an optional idle gap first; returns on acceptance
    task automatic send_beat(input t_in_beat b);
        if (take_gap()) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (take_gap());
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        if (b.opcode == OP_READ) read_items++;
        else                     row_items++;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_row(input logic [ROW_W-1:0] bits);
        t_in_beat b;
        b              = '0;
        b.opcode       = OP_ROW;
        b.row_bits     = bits;
        b.object_index = OBJ_AW'($urandom_range(0, 63));
        send_beat(b);
    endtask

    task automatic send_read(input logic [OBJ_AW-1:0] idx);
        t_in_beat b;
        b              = '0;
        b.opcode       = OP_READ;
        b.row_bits     = {$urandom, $urandom};
        b.object_index = idx;
        send_beat(b);
    endtask

    // Hold the sender until every predicted beat has come out
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // let the scan retire after its final beat
        repeat (2) @(posedge clk);
    endtask

    task automatic set_width(input logic [NUM_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_width = v;
        settings++;
    endtask

    // Random beat: mostly rows of varied shape, some readouts
    function automatic t_in_beat rand_beat(input int n);
        t_in_beat b;
        int       dens;
        int       target;
        int       k;
        int       p;
        b              = '0;
        b.object_index = OBJ_AW'($urandom_range(0, 63));
        b.row_bits     = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 15) begin
            b.opcode = OP_READ;
            return b;
        end
        b.opcode = OP_ROW;
        case ($urandom_range(0, 4))
            0, 1: ;
            2: begin
                dens = $urandom_range(0, 100);
                for (int i = 0; i < ROW_W; i++) b.row_bits[i] = $urandom_range(0, 99) < dens;
            end
            3: begin
                // ones count right at or just over the compaction threshold
                for (int i = 0; i < n; i++) b.row_bits[i] = 1'b0;
                target = n / 2 + $urandom_range(0, 1);
                if (target > n) target = n;
                k = 0;
                while (k < target) begin
                    p = $urandom_range(0, n - 1);
                    if (!b.row_bits[p]) begin
                        b.row_bits[p] = 1'b1;
                        k++;
                    end
                end
            end
            default: begin
                b.row_bits = $urandom_range(0, 1) ? '1 : '0;
                b.row_bits[$urandom_range(0, ROW_W - 1)] ^= 1'b1;
            end
        endcase
        return b;
    endfunction

    // Main stimulus
    initial begin
        logic [NUM_W-1:0] plan [12];
        int               eff;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // full-width rows: empty, all ones, single bits, threshold edges
        send_row('0);
        send_row('1);
        send_row(64'h1);
        send_row(64'h8000_0000_0000_0000);
        send_row(~64'h1);
        send_row(~64'h8000_0000_0000_0000);
        send_row(64'h0000_0000_FFFF_FFFF);
        send_row(64'h0000_0001_FFFF_FFFF);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_read(OBJ_AW'(0));
        send_read(OBJ_AW'(63));
        send_read(OBJ_AW'(31));

        // single object: a one compacts to an empty list
        set_width(NUM_W'(1));
        send_row(64'h1);
        send_row(64'h0);
        send_row(~64'h1);
        send_row('1);
        send_read(OBJ_AW'(0));

        // zero width: every row is skipped, readout still works
        set_width(NUM_W'(0));
        send_row('1);
        send_row('0);
        send_read(OBJ_AW'(5));

        // narrow row, bits above the width ignored
        set_width(NUM_W'(3));
        send_row(64'h3);
        send_row(64'h1);
        send_row(64'hFFFF_FFFF_FFFF_FFF8);

        // oversized width behaves as 64
        set_width(NUM_W'(127));
        send_row(64'h5555_5555_5555_5555);
        send_row('1);

        // random phases over several widths
        plan = '{NUM_W'(2), NUM_W'(64), NUM_W'(0), NUM_W'(127), NUM_W'(65), NUM_W'(1),
                 NUM_W'(63), NUM_W'(33), NUM_W'(7), NUM_W'(0), NUM_W'(0), NUM_W'(64)};
        plan[9]  = NUM_W'($urandom_range(0, 127));
        plan[10] = NUM_W'($urandom_range(2, 20));
        for (int ph = 0; ph < 12; ph++) begin
            set_width(plan[ph]);
            quiet = (ph == 4);
            eff   = (int'(cur_width) > MAX_OBJECTS) ? MAX_OBJECTS : int'(cur_width);
            repeat (30) begin
                send_beat(rand_beat(eff));
                if ($urandom_range(0, 39) == 0) drain();
            end
        end
        quiet = 1'b0;

        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d rows and %0d readouts over %0d width settings (0, 1, 64 and 127 among them).",
                 row_items, read_items, settings);
        $display("%0d output beats checked, %0d rows took the compacted path.",
                 beat_count, compacted_rows);
        if (fail_count == 0) begin
            $display("minority_bit_index_compactor test passed");
        end else begin
            $display("minority_bit_index_compactor test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("minority_bit_index_compactor test failed");
        $finish;
    end

endmodule
